[rtl/cubic_newton_root_finder_macros.svh]
// assertion macros for the cubic newton root finder
// used by the top level only
`ifndef CUBIC_NEWTON_ROOT_FINDER_MACROS_SVH
`define CUBIC_NEWTON_ROOT_FINDER_MACROS_SVH
`define CNR_ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("check failed");
`define CNR_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("check failed");
`endif

[rtl/cnr_pkg.sv]
// shared constants and the sat32 helper for the cubic newton root finder
// no dependencies
`timescale 1ns / 1ps
package cnr_pkg;
  localparam logic [2:0] ST_RUN  = 3'd0;
  localparam logic [2:0] ST_ROOT = 3'd1;
  localparam logic [2:0] ST_DZ   = 3'd2;
  localparam logic [2:0] ST_CONV = 3'd3;
  localparam logic [2:0] ST_NOCV = 3'd4;
  localparam logic [1:0] REG_A = 2'd0;
  localparam logic [1:0] REG_B = 2'd1;
  localparam logic [1:0] REG_C = 2'd2;
  localparam logic [1:0] REG_T = 2'd3;
  localparam logic signed [63:0] S32MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32MIN = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32MAX) sat32 = 32'sh7fffffff;
    else if (v < S32MIN) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction
endpackage

[rtl/cubic_newton_root_finder.sv]
// newton iteration on a monic cubic, Q16.16 saturating arithmetic
// one iterate: f by multiply-add (P1, P2, P3), f' (D1, D2), divider launch (DIV), divider wait (DW), check (CHK)
// (divider wait lasts until cnr_div reports done); at most ITER_LIM iterates per guess
// one word per iterate on out_valid, single-cycle strobe, no backpressure
// busy drops in the cycle the last word shows; next start accepted then
// synchronous active-low reset: coefficients zero, tolerance 65, idle
`timescale 1ns / 1ps
module cubic_newton_root_finder #(
  parameter int MAX_ITER = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_initial_guess,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  output logic signed [31:0] out_root_estimate,
  output logic signed [31:0] out_poly_value,
  output logic [2:0]         out_status,
  output logic               out_last
);
  `include "cubic_newton_root_finder_macros.svh"
  // iterate cap held to 1..64
  localparam int ITER_LIM = (MAX_ITER < 1) ? 1 : ((MAX_ITER > 64) ? 64 : MAX_ITER);
  localparam int IW = $clog2(ITER_LIM + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_P1 = 9'b000000010, S_P2 = 9'b000000100,
    S_P3 = 9'b000001000, S_D1 = 9'b000010000, S_D2 = 9'b000100000,
    S_DIV = 9'b001000000, S_DW = 9'b010000000, S_CHK = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic signed [31:0] a_r, b_r, c_r, x_r, f_r, d_r;
  logic [30:0] tol_r;
  logic [IW-1:0] k_r;
  logic signed [31:0] mp, mq, madd, mres;
  logic dgo, ddone;
  logic signed [31:0] dq;
  logic signed [31:0] y;
  logic signed [32:0] diff, adiff;
  logic signed [31:0] t0, t1;

  cnr_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .op_p(mp), .op_q(mq), .addend(madd), .res_r(mres));
  cnr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .num(f_r), .den(d_r),
    .done(ddone), .quo(dq));

  assign busy = (state_r != S_IDLE);
  // registers only change between runs
  assign cfg_ready = !busy;

  // operand selection for the shared multiply-add, and the newton update and its step size
  always_comb begin
    t0 = cnr_pkg::sat32(64'(x_r) + 64'(a_r));
    t1 = cnr_pkg::sat32(64'(x_r) * 3 + 64'(a_r) * 2);
    mp = t0; mq = x_r; madd = b_r;
    case (state_r)
      S_P1: begin mp = t0; madd = b_r; end
      S_P2: begin mp = mres; madd = c_r; end
      S_D1: begin mp = t1; madd = b_r; end
      default: ;
    endcase
    y = cnr_pkg::sat32(64'(x_r) - 64'(dq));
    diff = 33'(y) - 33'(x_r);
    adiff = diff[32] ? -diff : diff;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    dgo = 1'b0;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_P1;
      S_P1: state_nxt = S_P2;
      S_P2: state_nxt = S_P3;
      S_P3: state_nxt = (mres == 0) ? S_IDLE : S_D1;
      S_D1: state_nxt = S_D2;
      S_D2: state_nxt = (mres == 0) ? S_IDLE : S_DIV;
      S_DIV: begin dgo = 1'b1; state_nxt = S_DW; end
      S_DW: if (ddone) state_nxt = S_CHK;
      S_CHK: begin
        if ({1'b0, adiff[31:0]} <= {2'b0, tol_r} || k_r == IW'(ITER_LIM - 1))
          state_nxt = S_IDLE;
        else state_nxt = S_P1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      a_r <= '0; b_r <= '0; c_r <= '0; tol_r <= 31'd65;
      out_valid <= 1'b0;
      k_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cnr_pkg::REG_A: a_r <= cfg_data;
          cnr_pkg::REG_B: b_r <= cfg_data;
          cnr_pkg::REG_C: c_r <= cfg_data;
          cnr_pkg::REG_T: tol_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (start) begin x_r <= in_initial_guess; k_r <= '0; end
        S_P3: begin
          f_r <= mres;
          if (mres == 0) begin
            out_valid <= 1'b1; out_root_estimate <= x_r; out_poly_value <= '0;
            out_status <= cnr_pkg::ST_ROOT; out_last <= 1'b1;
          end
        end
        S_D2: begin
          d_r <= mres;
          if (mres == 0) begin
            out_valid <= 1'b1; out_root_estimate <= x_r; out_poly_value <= f_r;
            out_status <= cnr_pkg::ST_DZ; out_last <= 1'b1;
          end
        end
        S_CHK: begin
          out_valid <= 1'b1; out_root_estimate <= x_r; out_poly_value <= f_r;
          if ({1'b0, adiff[31:0]} <= {2'b0, tol_r}) begin
            out_status <= cnr_pkg::ST_CONV; out_last <= 1'b1;
          end else if (k_r == IW'(ITER_LIM - 1)) begin
            out_status <= cnr_pkg::ST_NOCV; out_last <= 1'b1;
          end else begin
            out_status <= cnr_pkg::ST_RUN; out_last <= 1'b0;
            x_r <= y; k_r <= k_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  `CNR_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `CNR_ASSERT_IMPL(a_last_idle, clk, rst_n, out_valid && out_last, !busy)
  `CNR_ASSERT_IMPL(a_iter_cap, clk, rst_n, busy, k_r < IW'(ITER_LIM))
endmodule

[rtl/cnr_div.sv]
// radix-2 restoring divider, one quotient bit per cycle, truncating signed
// no dependencies
`timescale 1ns / 1ps
module cnr_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] n_r, n_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   d_r;
  logic          neg_r, run_r, run_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [33:0]   trial;
  logic [NW:0]   qs;
  logic [NW-1:0] na;
  logic [31:0]   da;

  always_comb begin
    na = {(num[31] ? 32'(-num) : 32'(num)), {FRAC_BITS{1'b0}}};
    da = den[31] ? 32'(-den) : 32'(den);
    trial = {rem_r, n_r[NW-1]} - {2'b0, d_r};
  end

  // load on go, else shift-subtract step
  always_comb begin
    n_nxt = n_r;
    rem_nxt = rem_r;
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    if (go) begin
      n_nxt = na;
      rem_nxt = '0;
      run_nxt = 1'b1;
      cnt_nxt = CW'(NW);
    end else if (run_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        n_nxt = {n_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], n_r[NW-1]};
        n_nxt = {n_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt;
    rem_r <= rem_nxt;
    if (go) begin
      d_r <= da;
      neg_r <= num[31] ^ den[31];
    end
  end

  // sign fixup and saturation
  always_comb begin
    qs = neg_r ? (NW + 1)'(-{1'b0, n_r}) : {1'b0, n_r};
    if (!neg_r && n_r > NW'(64'h7fffffff)) quo = 32'sh7fffffff;
    else if (neg_r && n_r > NW'(64'h80000000)) quo = 32'sh80000000;
    else quo = qs[31:0];
  end
  assign done = run_r && (cnt_r == CW'(1)) ? 1'b0 : (!run_r);
endmodule

[rtl/cnr_mac.sv]
// shared multiply-add unit: sat(sat(round(p*q)) + addend), one result per cycle
// depends on cnr_pkg
`timescale 1ns / 1ps
module cnr_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic signed [31:0] op_p,
  input  logic signed [31:0] op_q,
  input  logic signed [31:0] addend,
  output logic signed [31:0] res_r
);
  logic signed [63:0] prod;
  logic signed [63:0] sh;
  logic signed [63:0] sum;

  always_comb begin
    prod = 64'(op_p) * 64'(op_q);
    sh = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    sum = 64'(cnr_pkg::sat32(sh)) + 64'(addend);
  end

  always_ff @(posedge clk) begin
    res_r <= cnr_pkg::sat32(sum);
  end
endmodule
